@@ sv/kems_pkg.sv @@
// ---------------------------------------------------------------------------
// kems_pkg
// Shared types and constants of the key event motor speed controller.
// ---------------------------------------------------------------------------
package kems_pkg;

  localparam int TimeW = 48;
  localparam int ThrW = 24;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_LINK_CLOSED = 2'd2;

  localparam logic [1:0] REG_MAX_LEVEL = 2'd0;
  localparam logic [1:0] REG_DUTY_PER_LEVEL = 2'd1;
  localparam logic [1:0] REG_HOLD_THRESHOLD = 2'd2;

  localparam logic [15:0] USE_NEXT = 16'h00B5;
  localparam logic [15:0] USE_PREV = 16'h00B6;
  localparam logic [15:0] USE_VOLUP = 16'h00E9;
  localparam logic [15:0] USE_VOLDN = 16'h00EA;
  localparam logic [15:0] USE_PLAY = 16'h00CD;

  localparam logic [7:0] KEY_UP = 8'hE9;
  localparam logic [7:0] KEY_DOWN = 8'hEA;
  localparam logic [7:0] KEY_STOP = 8'hCD;

  localparam logic [6:0] MAX_LEVEL_RESET = 7'd10;
  localparam logic [7:0] DUTY_PER_LEVEL_RESET = 8'd25;
  localparam logic [23:0] HOLD_THRESHOLD_RESET = 24'd500000;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_TICK,
    CMD_UP,
    CMD_DOWN,
    CMD_JUMP_POS,
    CMD_JUMP_NEG,
    CMD_HALT,
    CMD_PRESS,
    CMD_RELEASE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [7:0] key;
    logic [TimeW-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [6:0] max_level;
    logic [7:0] duty_per_level;
    logic [ThrW-1:0] hold_threshold;
  } cfg_t;

endpackage

@@ sv/key_event_motor_speed_controller.sv @@
// ---------------------------------------------------------------------------
// key_event_motor_speed_controller
// Speed level, enable and long-press control from remote key events.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive the event fields and raise push; the event is taken
//   at a clock edge where full is low. One result per event.
//   Result queue: while empty is low the oldest result sits on pwm_duty,
//   forward, level_now, enabled_now and long_now; pop takes it.
//   Configuration: cfg_write with cfg_index and cfg_data writes max_level,
//   duty_per_level or hold_threshold_us; write only while no event is
//   outstanding. Indexes beyond the list are ignored.
//   Path: command queue, execute stage register, output register.
//   Throughput: one event per cycle while no held result stalls, set by
//   the state update in the execute stage; duty scaling has its own register.
//   Reset (rst, synchronous): state clears to zero, registers take their
//   defaults, both queues empty.
//   Stall: a held result freezes the pipeline; the two-entry command queue
//   then fills and full rises.
// ---------------------------------------------------------------------------
module key_event_motor_speed_controller (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0] operation,
  input  logic [47:0] now_us,
  input  logic [7:0] report_length,
  input  logic [7:0] report_byte0,
  input  logic [7:0] report_byte1,
  input  logic [7:0] report_byte2,
  output logic empty,
  input  logic pop,
  output logic [14:0] pwm_duty,
  output logic forward,
  output logic signed [7:0] level_now,
  output logic enabled_now,
  output logic long_now,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_data
);

  kems_pkg::cfg_t cfg;
  kems_pkg::cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_level <= kems_pkg::MAX_LEVEL_RESET;
      cfg.duty_per_level <= kems_pkg::DUTY_PER_LEVEL_RESET;
      cfg.hold_threshold <= kems_pkg::HOLD_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        kems_pkg::REG_MAX_LEVEL: cfg.max_level <= cfg_data[6:0];
        kems_pkg::REG_DUTY_PER_LEVEL: cfg.duty_per_level <= cfg_data[7:0];
        kems_pkg::REG_HOLD_THRESHOLD: cfg.hold_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  kems_front u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .now_us(now_us),
    .report_length(report_length),
    .report_byte0(report_byte0),
    .report_byte1(report_byte1),
    .report_byte2(report_byte2),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop)
  );

  kems_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop),
    .empty(empty),
    .pop(pop),
    .pwm_duty(pwm_duty),
    .forward(forward),
    .level_now(level_now),
    .enabled_now(enabled_now),
    .long_now(long_now)
  );

endmodule

@@ sv/kems_front.sv @@
// ---------------------------------------------------------------------------
// kems_front
// Accepts events, decodes them into commands and queues them (two entries).
// ---------------------------------------------------------------------------
module kems_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0] operation,
  input  logic [kems_pkg::TimeW-1:0] now_us,
  input  logic [7:0] report_length,
  input  logic [7:0] report_byte0,
  input  logic [7:0] report_byte1,
  input  logic [7:0] report_byte2,
  output logic cmd_valid,
  output kems_pkg::cmd_t cmd,
  input  logic cmd_pop
);

  kems_pkg::cmd_t dec;
  kems_pkg::cmd_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_push;
  logic do_pop;
  logic [15:0] usage;
  logic pressed;

  assign usage = {report_byte2, report_byte1};
  assign pressed = (report_byte0 != 8'd0);

  always_comb begin
    dec.kind = kems_pkg::CMD_NONE;
    dec.key = report_byte1;
    dec.now = now_us;
    case (operation)
      kems_pkg::OP_TICK: dec.kind = kems_pkg::CMD_TICK;
      kems_pkg::OP_REPORT: begin
        if (report_length >= 8'd3) begin
          if (pressed) begin
            case (usage)
              kems_pkg::USE_NEXT: dec.kind = kems_pkg::CMD_UP;
              kems_pkg::USE_PREV: dec.kind = kems_pkg::CMD_DOWN;
              kems_pkg::USE_VOLUP: dec.kind = kems_pkg::CMD_JUMP_POS;
              kems_pkg::USE_VOLDN: dec.kind = kems_pkg::CMD_JUMP_NEG;
              kems_pkg::USE_PLAY: dec.kind = kems_pkg::CMD_HALT;
              default: dec.kind = kems_pkg::CMD_NONE;
            endcase
          end
        end else if (report_length == 8'd2) begin
          dec.kind = pressed ? kems_pkg::CMD_PRESS : kems_pkg::CMD_RELEASE;
        end
      end
      kems_pkg::OP_LINK_CLOSED: dec.kind = kems_pkg::CMD_HALT;
      default: dec.kind = kems_pkg::CMD_NONE;
    endcase
  end

  assign full = (count == 2'd2);
  assign do_push = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop = cmd_pop && cmd_valid;
  assign cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/kems_back.sv @@
// ---------------------------------------------------------------------------
// kems_back
// Executes commands against the speed state, then scales the level to duty.
// ---------------------------------------------------------------------------
module kems_back (
  input  logic clk,
  input  logic rst,
  input  kems_pkg::cfg_t cfg,
  input  logic cmd_valid,
  input  kems_pkg::cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  input  logic pop,
  output logic [14:0] pwm_duty,
  output logic forward,
  output logic signed [7:0] level_now,
  output logic enabled_now,
  output logic long_now
);

  logic signed [7:0] cur_level;
  logic motor_on;
  logic long_active;
  logic key_held;
  logic [7:0] held_code;
  logic [kems_pkg::TimeW-1:0] press_time;

  logic signed [7:0] cur_level_next;
  logic motor_on_next;
  logic long_active_next;
  logic key_held_next;
  logic [7:0] held_code_next;
  logic [kems_pkg::TimeW-1:0] press_time_next;

  logic signed [7:0] max_s;
  logic signed [7:0] neg_max;
  logic up_ok;
  logic dn_ok;
  logic signed [7:0] up_level;
  logic signed [7:0] dn_level;
  logic [kems_pkg::TimeW-1:0] elapsed;
  logic short_hold;

  logic s1_valid;
  logic [6:0] s1_mag;
  logic s1_fwd;
  logic signed [7:0] s1_level;
  logic s1_en;
  logic s1_long;
  logic out_valid;
  logic out_ready;
  logic s1_ready;
  logic [6:0] mag_next;
  logic signed [7:0] abs_level;
  logic [14:0] product;

  assign max_s = signed'({1'b0, cfg.max_level});
  assign neg_max = -max_s;
  assign up_ok = (cur_level < max_s);
  assign dn_ok = (cur_level > neg_max);
  assign up_level = cur_level + 8'sd1;
  assign dn_level = cur_level - 8'sd1;
  assign elapsed = cmd.now - press_time;
  assign short_hold = (elapsed < {{(kems_pkg::TimeW-kems_pkg::ThrW){1'b0}},
                                  cfg.hold_threshold});

  always_comb begin
    cur_level_next = cur_level;
    motor_on_next = motor_on;
    long_active_next = long_active;
    key_held_next = key_held;
    held_code_next = held_code;
    press_time_next = press_time;
    case (cmd.kind)
      kems_pkg::CMD_TICK: begin
        if (key_held && !long_active && !short_hold) begin
          long_active_next = 1'b1;
          if (held_code == kems_pkg::KEY_UP) begin
            cur_level_next = max_s;
            motor_on_next = 1'b1;
          end else if (held_code == kems_pkg::KEY_DOWN) begin
            cur_level_next = neg_max;
            motor_on_next = 1'b1;
          end
        end
      end
      kems_pkg::CMD_UP: begin
        if (up_ok) begin
          cur_level_next = up_level;
          motor_on_next = 1'b1;
        end
      end
      kems_pkg::CMD_DOWN: begin
        if (dn_ok) begin
          cur_level_next = dn_level;
          motor_on_next = (dn_level != 8'sd0);
        end
      end
      kems_pkg::CMD_JUMP_POS: begin
        cur_level_next = max_s;
        motor_on_next = 1'b1;
        long_active_next = 1'b1;
      end
      kems_pkg::CMD_JUMP_NEG: begin
        cur_level_next = neg_max;
        motor_on_next = 1'b1;
        long_active_next = 1'b1;
      end
      kems_pkg::CMD_HALT: begin
        cur_level_next = 8'sd0;
        motor_on_next = 1'b0;
        long_active_next = 1'b0;
      end
      kems_pkg::CMD_PRESS: begin
        key_held_next = 1'b1;
        held_code_next = cmd.key;
        press_time_next = cmd.now;
        if (cmd.key == kems_pkg::KEY_STOP) begin
          cur_level_next = 8'sd0;
          motor_on_next = 1'b0;
          long_active_next = 1'b0;
        end
      end
      kems_pkg::CMD_RELEASE: begin
        if (key_held && held_code == cmd.key) begin
          key_held_next = 1'b0;
          held_code_next = 8'd0;
          if (long_active) begin
            cur_level_next = 8'sd0;
            motor_on_next = 1'b0;
            long_active_next = 1'b0;
          end else if (short_hold) begin
            if (cmd.key == kems_pkg::KEY_UP && up_ok) begin
              cur_level_next = up_level;
              motor_on_next = 1'b1;
            end else if (cmd.key == kems_pkg::KEY_DOWN && dn_ok) begin
              cur_level_next = dn_level;
              motor_on_next = (dn_level != 8'sd0);
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Pipeline handshake: advance when the next stage is free or draining.
  assign out_ready = !out_valid || pop;
  assign s1_ready = !s1_valid || out_ready;
  assign cmd_pop = cmd_valid && s1_ready;

  assign abs_level = (cur_level_next < 8'sd0) ? -cur_level_next : cur_level_next;
  assign mag_next = (motor_on_next && cur_level_next != 8'sd0) ? abs_level[6:0] : 7'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level <= 8'sd0;
      motor_on <= 1'b0;
      long_active <= 1'b0;
      key_held <= 1'b0;
      held_code <= 8'd0;
      press_time <= '0;
    end else if (cmd_pop) begin
      cur_level <= cur_level_next;
      motor_on <= motor_on_next;
      long_active <= long_active_next;
      key_held <= key_held_next;
      held_code <= held_code_next;
      press_time <= press_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_mag <= mag_next;
      s1_fwd <= !(motor_on_next && cur_level_next < 8'sd0);
      s1_level <= cur_level_next;
      s1_en <= motor_on_next;
      s1_long <= long_active_next;
    end
  end

  assign product = {8'd0, s1_mag} * {7'd0, cfg.duty_per_level};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      pwm_duty <= product;
      forward <= s1_fwd;
      level_now <= s1_level;
      enabled_now <= s1_en;
      long_now <= s1_long;
    end
  end

  assign empty = !out_valid;

endmodule

@@ bench/key_event_motor_speed_controller_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// key_event_motor_speed_controller_test
// Self-checking bench for the key event motor speed controller. A directed
// pass walks every usage, key press and release, tick, link drop and the
// ignored reports at the reset settings, and a subset at the register
// extremes. A random pass then runs key gestures, usages, ticks and noise
// under several register settings. Both queue sides stall at random. A
// tracker predicts the drive state after every accepted request and
// checks each popped result in order.
// ---------------------------------------------------------------------------
module key_event_motor_speed_controller_test;
  import kems_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PhaseItems = 200;

  typedef struct {
    logic [14:0] duty;
    logic fwd;
    logic signed [7:0] level;
    logic en;
    logic lng;
  } drive_t;

  class speed_tracker;
    cfg_t cfg;
    int level;
    bit on;
    bit lng;
    bit held;
    logic [7:0] held_key;
    logic [TimeW-1:0] pressed_at;
    drive_t pending_drive[$];
    int errors;
    int compared;

    function new();
      cfg.max_level = MAX_LEVEL_RESET;
      cfg.duty_per_level = DUTY_PER_LEVEL_RESET;
      cfg.hold_threshold = HOLD_THRESHOLD_RESET;
      level = 0;
      on = 0;
      lng = 0;
      held = 0;
      held_key = '0;
      pressed_at = '0;
      errors = 0;
      compared = 0;
    endfunction

    function void set_config(logic [6:0] m, logic [7:0] g, logic [ThrW-1:0] h);
      cfg.max_level = m;
      cfg.duty_per_level = g;
      cfg.hold_threshold = h;
    endfunction

    function void step_up();
      if (level < int'(cfg.max_level)) begin
        level++;
        on = 1;
      end
    endfunction

    function void step_down();
      if (level > -int'(cfg.max_level)) begin
        level--;
        on = (level != 0);
      end
    endfunction

    function void jump(int lvl);
      level = lvl;
      on = 1;
      lng = 1;
    endfunction

    function void halt();
      level = 0;
      on = 0;
      lng = 0;
    endfunction

    function void note_event(logic [1:0] op, logic [TimeW-1:0] t, logic [7:0] len,
                             logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      logic [TimeW-1:0] dur;
      logic [15:0] usage;
      int unsigned mag;
      drive_t d;
      dur = t - pressed_at;
      usage = {b2, b1};
      case (op)
        OP_TICK: begin
          if (held && !lng && dur >= {24'd0, cfg.hold_threshold}) begin
            lng = 1;
            if (held_key == KEY_UP) jump(int'(cfg.max_level));
            else if (held_key == KEY_DOWN) jump(-int'(cfg.max_level));
          end
        end
        OP_REPORT: begin
          if (len >= 8'd3) begin
            if (b0 != 8'd0) begin
              case (usage)
                USE_NEXT: step_up();
                USE_PREV: step_down();
                USE_VOLUP: jump(int'(cfg.max_level));
                USE_VOLDN: jump(-int'(cfg.max_level));
                USE_PLAY: halt();
                default: ;
              endcase
            end
          end else if (len == 8'd2) begin
            if (b0 != 8'd0) begin
              held = 1;
              held_key = b1;
              pressed_at = t;
              if (b1 == KEY_STOP) halt();
            end else if (held && held_key == b1) begin
              held = 0;
              held_key = '0;
              if (lng) halt();
              else if (dur < {24'd0, cfg.hold_threshold}) begin
                if (b1 == KEY_UP) step_up();
                else if (b1 == KEY_DOWN) step_down();
              end
            end
          end
        end
        OP_LINK_CLOSED: halt();
        default: ;
      endcase
      d.level = level[7:0];
      d.en = on;
      d.lng = lng;
      d.duty = '0;
      d.fwd = 1'b1;
      if (on && level != 0) begin
        mag = (level < 0) ? -level : level;
        d.duty = 15'(mag * cfg.duty_per_level);
        d.fwd = (level > 0);
      end
      pending_drive.push_back(d);
    endfunction

    function void check_drive(logic [14:0] duty, logic fwd, logic signed [7:0] lvl,
                              logic en, logic lng_out);
      drive_t e;
      if (pending_drive.size() == 0) begin
        errors++;
        $display("%0t: unexpected result duty %0d fwd %0b level %0d en %0b long %0b",
                 $time, duty, fwd, lvl, en, lng_out);
        return;
      end
      e = pending_drive.pop_front();
      compared++;
      if ({e.duty, e.fwd, e.level, e.en, e.lng} !== {duty, fwd, lvl, en, lng_out}) begin
        errors++;
        $display("%0t: expected duty %0d fwd %0b level %0d en %0b long %0b", $time,
                 e.duty, e.fwd, e.level, e.en, e.lng);
        $display("%0t:   actual duty %0d fwd %0b level %0d en %0b long %0b", $time,
                 duty, fwd, lvl, en, lng_out);
      end
    endfunction

    function int pending();
      return pending_drive.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] operation = '0;
  logic [47:0] now_us = '0;
  logic [7:0] report_length = '0;
  logic [7:0] report_byte0 = '0;
  logic [7:0] report_byte1 = '0;
  logic [7:0] report_byte2 = '0;
  logic empty;
  logic pop = 1'b0;
  logic [14:0] pwm_duty;
  logic forward;
  logic signed [7:0] level_now;
  logic enabled_now;
  logic long_now;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  speed_tracker tracker;
  bit pushing = 0;
  bit quiet = 0;
  int sent = 0;
  int settings = 0;
  int stall_left = 0;
  logic [TimeW-1:0] clock_us = '0;

  key_event_motor_speed_controller uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .now_us(now_us),
    .report_length(report_length),
    .report_byte0(report_byte0),
    .report_byte1(report_byte1),
    .report_byte2(report_byte2),
    .empty(empty),
    .pop(pop),
    .pwm_duty(pwm_duty),
    .forward(forward),
    .level_now(level_now),
    .enabled_now(enabled_now),
    .long_now(long_now),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && pop && !empty) tracker.check_drive(pwm_duty, forward, level_now, enabled_now,
                                                   long_now);
    if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic pause(input int n);
    if (pushing) push <= 1'b0;
    pushing = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_event(input logic [1:0] op, input logic [47:0] t, input logic [7:0] len,
                            input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    if (!pushing) push <= 1'b1;
    pushing = 1;
    operation <= op;
    now_us <= t;
    report_length <= len;
    report_byte0 <= b0;
    report_byte1 <= b1;
    report_byte2 <= b2;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_event(op, t, len, b0, b1, b2);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 4));
  endtask

  task automatic send_usage(input logic [15:0] usage);
    send_event(OP_REPORT, clock_us, 8'd3, 8'd1, usage[7:0], usage[15:8]);
  endtask

  task automatic send_key(input logic [7:0] b0, input logic [7:0] key);
    send_event(OP_REPORT, clock_us, 8'd2, b0, key, 8'($urandom));
  endtask

  task automatic send_tick();
    send_event(OP_TICK, clock_us, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_all_results();
    pause(0);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [6:0] m, input logic [7:0] g, input logic [23:0] h);
    logic [23:0] junk;
    wait_all_results();
    junk = 24'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_LEVEL;
    cfg_data <= {junk[23:7], m};
    @(posedge clk);
    cfg_index <= REG_DUTY_PER_LEVEL;
    cfg_data <= {junk[15:0], g};
    @(posedge clk);
    cfg_index <= REG_HOLD_THRESHOLD;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data <= junk;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_config(m, g, h);
    settings++;
  endtask

  task automatic advance_clock();
    int unsigned thr;
    thr = tracker.cfg.hold_threshold;
    if ($urandom_range(0, 19) == 0) clock_us = {16'($urandom), 32'($urandom)};
    else clock_us += $urandom_range(0, thr + thr / 2 + 3);
  endtask

  task automatic random_event();
    int pick;
    logic [7:0] key;
    logic [15:0] usage;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: key = KEY_UP;
      1: key = KEY_DOWN;
      2: key = KEY_STOP;
      default: key = 8'($urandom);
    endcase
    if (pick < 30) begin
      advance_clock();
      send_key(8'($urandom_range(1, 255)), key);
      repeat ($urandom_range(0, 3)) begin
        advance_clock();
        send_tick();
      end
      advance_clock();
      if ($urandom_range(0, 9) == 0) key = 8'($urandom);
      send_key(8'd0, key);
    end else if (pick < 55) begin
      case ($urandom_range(0, 5))
        0: usage = USE_NEXT;
        1: usage = USE_PREV;
        2: usage = USE_VOLUP;
        3: usage = USE_VOLDN;
        4: usage = USE_PLAY;
        default: usage = 16'($urandom);
      endcase
      send_event(OP_REPORT, clock_us,
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(3, 255)) : 8'd3,
                 ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                 usage[7:0], usage[15:8]);
    end else if (pick < 75) begin
      advance_clock();
      send_tick();
    end else if (pick < 80) begin
      send_event(OP_LINK_CLOSED, clock_us, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    end else if (pick < 90) begin
      advance_clock();
      send_key(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom), key);
    end else begin
      send_event(2'($urandom), {16'($urandom), 32'($urandom)},
                 ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    #5_000_000;
    $display("timeout: %0d results still outstanding", tracker.pending());
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase_start;
    bit drained_mid;
    tracker = new();
    drained_mid = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(OP_TICK, 48'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_usage(USE_NEXT);
    send_usage(USE_PREV);
    send_usage(USE_PREV);
    send_usage(USE_VOLUP);
    send_usage(USE_VOLDN);
    send_usage(USE_PLAY);
    send_event(OP_REPORT, clock_us, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_event(OP_REPORT, clock_us, 8'd0, 8'hFF, KEY_STOP, 8'hFF);
    send_event(OP_REPORT, clock_us, 8'd1, 8'hFF, KEY_UP, 8'h00);
    clock_us = 48'hFFFF_FFFF_FFF0;
    send_key(8'hFF, KEY_UP);
    clock_us = 48'h20;
    send_key(8'h00, KEY_UP);
    clock_us = 48'd1000;
    send_key(8'h01, KEY_DOWN);
    clock_us = 48'd501000;
    send_tick();
    send_key(8'h00, KEY_DOWN);
    send_key(8'h01, KEY_STOP);
    send_event(OP_LINK_CLOSED, clock_us, 8'd0, 8'd0, 8'd0, 8'd0);
    send_key(8'h00, KEY_UP);
    send_key(8'h00, KEY_STOP);
    send_event(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_key(8'h80, 8'h41);
    clock_us = 48'hFFFF_FFFF_FFFF;
    send_tick();
    send_key(8'h00, 8'h41);
    reconfigure(7'd127, 8'd255, 24'hFFFFFF);
    send_usage(USE_VOLUP);
    send_usage(USE_NEXT);
    reconfigure(7'd1, 8'd0, 24'd0);
    send_usage(USE_PREV);
    send_key(8'h01, KEY_UP);
    send_tick();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: reconfigure(7'd127, 8'd255, 24'hFFFFFF);
        1: reconfigure(7'd1, 8'd0, 24'd0);
        3: reconfigure(7'd127, 8'd1, 24'($urandom_range(0, 1000)));
        6: reconfigure(MAX_LEVEL_RESET, DUTY_PER_LEVEL_RESET, HOLD_THRESHOLD_RESET);
        default: reconfigure(7'($urandom_range(1, 127)), 8'($urandom), 24'($urandom));
      endcase
      if (p == 4) clock_us = 48'hFFFF_FFFF_0000;
      phase_start = sent;
      while (sent - phase_start < PhaseItems) begin
        if (p == 6 && sent - phase_start >= 50) quiet = 1;
        if (p == 2 && sent - phase_start >= PhaseItems / 2 && !drained_mid) begin
          wait_all_results();
          drained_mid = 1;
        end
        random_event();
      end
    end

    pause(0);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d events under %0d register settings, %0d results compared",
             sent, settings + 1, tracker.compared);
    $display("mismatches: %0d", tracker.errors);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ key_event_motor_speed_controller.f @@
sv/kems_pkg.sv
sv/kems_front.sv
sv/kems_back.sv
sv/key_event_motor_speed_controller.sv
bench/key_event_motor_speed_controller_test.sv
